// ===== hdl/texture_sample_bilinear_top_assert.svh =====
// Assertion macros for the texture sampler. Each check is clocked on clk
// and is held off while rst is high.
`ifndef TEXTURE_SAMPLE_BILINEAR_TOP_ASSERT_SVH
`define TEXTURE_SAMPLE_BILINEAR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// The expression holds at every clock edge.
`define TSB_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("texture sampler check failed");

// When the first expression holds, the second holds in the next cycle.
`define TSB_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("texture sampler check failed");

`else

`define TSB_ASSERT_ALWAYS(label, expr)
`define TSB_ASSERT_NEXT(label, pre, post)

`endif

`endif

// ===== hdl/tsb_pkg.sv =====
`timescale 1ns / 1ps

package tsb_pkg;

  // Texel store geometry.
  localparam int StoreAddrBits = 12;
  localparam int StoreDepth    = 4096;
  localparam int TexelBits     = 32;

  // Configuration port.
  localparam int CfgAddrBits = 5;
  localparam logic [2:0] RegTexWidth  = 3'd0;
  localparam logic [2:0] RegTexHeight = 3'd1;
  localparam logic [2:0] RegModeU     = 3'd2;
  localparam logic [2:0] RegModeV     = 3'd3;
  localparam logic [2:0] RegFilter    = 3'd4;
  localparam logic [2:0] RegFormat    = 3'd5;
  localparam logic [2:0] RegSwizzle   = 3'd6;

  // Commands.
  localparam logic CmdWrite  = 1'b0;
  localparam logic CmdSample = 1'b1;

  // Address modes.
  localparam logic [1:0] ModeRepeat = 2'd0;
  localparam logic [1:0] ModeMirror = 2'd1;
  localparam logic [1:0] ModeClamp  = 2'd2;
  localparam logic [1:0] ModeBorder = 2'd3;

  // Filters.
  localparam logic FilterNearest  = 1'b0;
  localparam logic FilterBilinear = 1'b1;

  // Pixel formats.
  localparam logic [1:0] FmtUndef = 2'd0;
  localparam logic [1:0] FmtR8    = 2'd1;
  localparam logic [1:0] FmtRgba  = 2'd2;
  localparam logic [1:0] FmtBgra  = 2'd3;

  // Swizzle selectors.
  localparam logic [2:0] SwzIdent = 3'd0;
  localparam logic [2:0] SwzZero  = 3'd1;
  localparam logic [2:0] SwzOne   = 3'd2;
  localparam logic [2:0] SwzR     = 3'd3;
  localparam logic [2:0] SwzG     = 3'd4;
  localparam logic [2:0] SwzB     = 3'd5;
  localparam logic [2:0] SwzA     = 3'd6;

  // Result queue.
  localparam int FifoDepth   = 8;
  localparam int FifoPtrBits = 3;
  localparam int FifoCntBits = 4;

  typedef struct packed {
    logic                     command;
    logic [11:0]              texel_address;
    logic [31:0]              texel_data;
    logic signed [23:0]       coord_u;
    logic signed [23:0]       coord_v;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } out_word_t;

  // Channel bytes, index 0 red through 3 alpha.
  typedef logic [3:0][7:0] rgba_t;

  // Unpack one stored word according to the pixel format.
  function automatic rgba_t decode_texel(logic [31:0] w, logic [1:0] fmt);
    rgba_t t;
    t = {8'hFF, 8'h00, 8'h00, 8'h00};
    case (fmt)
      FmtR8: begin
        t[0] = w[7:0];
      end
      FmtRgba: begin
        t = {w[31:24], w[23:16], w[15:8], w[7:0]};
      end
      FmtBgra: begin
        t = {w[31:24], w[7:0], w[15:8], w[23:16]};
      end
      default: begin
        t = {8'hFF, 8'h00, 8'h00, 8'h00};
      end
    endcase
    return t;
  endfunction

  // Pick one output channel through its swizzle selector.
  function automatic logic [7:0] swizzle_one(rgba_t t, logic [2:0] sel, logic [7:0] ident);
    logic [7:0] b;
    case (sel)
      SwzZero: b = 8'h00;
      SwzOne:  b = 8'hFF;
      SwzR:    b = t[0];
      SwzG:    b = t[1];
      SwzB:    b = t[2];
      SwzA:    b = t[3];
      default: b = ident;
    endcase
    return b;
  endfunction

  // Wrap one texel coordinate. r is the position within the period that
  // the integer part lands on (from -1 to s), odd tells whether the
  // integer part is odd, and full is the whole texel position for clamping.
  function automatic logic [6:0] wrap_coord(logic [6:0] s, logic odd, logic signed [8:0] r,
                                            logic signed [16:0] full, logic [1:0] mode);
    logic signed [9:0]  sz;
    logic signed [9:0]  two;
    logic signed [9:0]  m;
    logic signed [16:0] sfull;
    logic [6:0]         res;
    sz    = $signed(10'(s));
    two   = sz + sz;
    m     = 10'(r) + (odd ? sz : 10'sd0);
    sfull = $signed(17'(s));
    res   = '0;
    if (s == 7'd0) begin
      res = '0;
    end else begin
      case (mode)
        ModeRepeat: begin
          if (r < 9'sd0) res = s - 7'd1;
          else if (10'(r) >= sz) res = '0;
          else res = r[6:0];
        end
        ModeMirror: begin
          if (m < 10'sd0) m = m + two;
          else if (m >= two) m = m - two;
          if (m < sz) res = m[6:0];
          else res = 7'(two - 10'sd1 - m);
        end
        default: begin
          if (full < 17'sd0) res = '0;
          else if (full >= sfull) res = s - 7'd1;
          else res = full[6:0];
        end
      endcase
    end
    return res;
  endfunction

endpackage

// ===== hdl/tsb_in_if.sv =====
`timescale 1ns / 1ps

interface tsb_in_if import tsb_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

// ===== hdl/tsb_out_if.sv =====
`timescale 1ns / 1ps

interface tsb_out_if import tsb_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

// ===== hdl/tsb_ram.sv =====
`timescale 1ns / 1ps

module tsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== hdl/texture_sample_bilinear_top.sv =====
// Texture sampler over a 4096-word texel store.
// sample_in carries one word per command: a write stores texel_data at
// texel_address and gives no result; a sample takes signed Q8.16 coord_u
// and coord_v and gives one RGBA word on sample_out. Texture size, address
// modes, filter, pixel format and swizzle are to be set over the APB port while
// the unit is idle; the block does not enforce this. pready is always high.
// Writes and nearest samples are taken one per cycle while nothing stalls the
// pipeline; a bilinear sample holds the single texel store port for one read
// per neighbor, so the next command reaches the port only after its fourth read.
// Results collect in an 8-word queue; a sample enters the store port only
// while the queue has room for it, so a stalled receiver backs up the
// pipeline until sample_in drops ready, and nothing is lost.
// Reset returns the registers to width 1, height 1, repeat, nearest, RGBA,
// identity swizzle and empties the pipeline. The texel store is not
// cleared; texels must be written before they are sampled.
`timescale 1ns / 1ps
`include "texture_sample_bilinear_top_assert.svh"

module texture_sample_bilinear_top import tsb_pkg::*; #(
  parameter int MAX_DIM     = 64,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  tsb_in_if.sink                 sample_in,
  tsb_out_if.source              sample_out,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CfgAddrBits-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int SizeCap = (MAX_DIM < 127) ? MAX_DIM : 127;
  localparam int WB      = WEIGHT_BITS;
  localparam int BlW     = WB + 9;
  localparam int SumW    = 2 * WB + 10;
  localparam logic [WB:0]     WeightOne = (WB + 1)'(1 << WB);
  localparam logic [SumW-1:0] Half      = SumW'(1) << (2 * WB - 1);

  // Configuration registers.
  logic [6:0]  tex_width;
  logic [6:0]  tex_height;
  logic [1:0]  address_mode_u;
  logic [1:0]  address_mode_v;
  logic        filter_mode;
  logic [1:0]  pixel_format;
  logic [11:0] channel_swizzle;
  logic        cfg_write;
  logic [2:0]  cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width       <= 7'd1;
      tex_height      <= 7'd1;
      address_mode_u  <= ModeRepeat;
      address_mode_v  <= ModeRepeat;
      filter_mode     <= FilterNearest;
      pixel_format    <= FmtRgba;
      channel_swizzle <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        RegTexWidth:  tex_width       <= pwdata[6:0];
        RegTexHeight: tex_height      <= pwdata[6:0];
        RegModeU:     address_mode_u  <= pwdata[1:0];
        RegModeV:     address_mode_v  <= pwdata[1:0];
        RegFilter:    filter_mode     <= pwdata[0];
        RegFormat:    pixel_format    <= pwdata[1:0];
        RegSwizzle:   channel_swizzle <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (cfg_index)
      RegTexWidth:  prdata = 32'(tex_width);
      RegTexHeight: prdata = 32'(tex_height);
      RegModeU:     prdata = 32'(address_mode_u);
      RegModeV:     prdata = 32'(address_mode_v);
      RegFilter:    prdata = 32'(filter_mode);
      RegFormat:    prdata = 32'(pixel_format);
      RegSwizzle:   prdata = 32'(channel_swizzle);
      default:      prdata = '0;
    endcase
  end

  // Effective texture size, saturated at the maximum dimension.
  logic [6:0] size_u;
  logic [6:0] size_v;
  assign size_u = (tex_width  > 7'(SizeCap)) ? 7'(SizeCap) : tex_width;
  assign size_v = (tex_height > 7'(SizeCap)) ? 7'(SizeCap) : tex_height;

  // Pipeline control.
  logic s1_valid, s2_valid, s3_valid;
  logic s1_move, s2_move, s3_done;

  // Stage 1: input register.
  in_word_t s1_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_in.ready) begin
      s1_valid <= sample_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_in.ready && sample_in.valid) begin
      s1_word <= sample_in.word;
    end
  end

  assign s1_move         = s1_valid && (!s2_valid || s2_move);
  assign sample_in.ready = !s1_valid || s1_move;

  // Stage 2: scale the fraction and the integer part by the size.
  logic               s2_cmd;
  logic [11:0]        s2_waddr;
  logic [31:0]        s2_wdata;
  logic [22:0]        fs_u, fs_v;
  logic signed [15:0] base_u, base_v;
  logic               odd_u, odd_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (!s2_valid || s2_move) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_cmd   <= s1_word.command;
      s2_waddr <= s1_word.texel_address;
      s2_wdata <= s1_word.texel_data;
      fs_u     <= {7'b0, s1_word.coord_u[15:0]} * {16'b0, size_u};
      fs_v     <= {7'b0, s1_word.coord_v[15:0]} * {16'b0, size_v};
      base_u   <= $signed(s1_word.coord_u[23:16]) * $signed({1'b0, size_u});
      base_v   <= $signed(s1_word.coord_v[23:16]) * $signed({1'b0, size_v});
      odd_u    <= s1_word.coord_u[16];
      odd_v    <= s1_word.coord_v[16];
    end
  end

  assign s2_move = s2_valid && (!s3_valid || s3_done);

  // Stage 2 logic: texel positions, wrapping and weights.
  logic signed [23:0] qf_u, qf_v;
  logic signed [8:0]  rn_u, rn_v, r0_u, r0_v, r1_u, r1_v;
  logic signed [16:0] fn_u, fn_v, f0_u, f0_v, f1_u, f1_v;
  logic [6:0]         x0, x1, y0, y1;
  logic [WB-1:0]      wx, wy;

  assign qf_u = $signed({1'b0, fs_u}) - 24'sd32768;
  assign qf_v = $signed({1'b0, fs_v}) - 24'sd32768;
  assign rn_u = 9'($signed({1'b0, fs_u[22:16]}));
  assign rn_v = 9'($signed({1'b0, fs_v[22:16]}));
  assign r0_u = 9'($signed(qf_u[23:16]));
  assign r0_v = 9'($signed(qf_v[23:16]));
  assign r1_u = r0_u + 9'sd1;
  assign r1_v = r0_v + 9'sd1;
  assign fn_u = 17'(base_u) + 17'(rn_u);
  assign fn_v = 17'(base_v) + 17'(rn_v);
  assign f0_u = 17'(base_u) + 17'(r0_u);
  assign f0_v = 17'(base_v) + 17'(r0_v);
  assign f1_u = f0_u + 17'sd1;
  assign f1_v = f0_v + 17'sd1;

  always_comb begin
    if (filter_mode == FilterBilinear) begin
      x0 = wrap_coord(size_u, odd_u, r0_u, f0_u, address_mode_u);
      x1 = wrap_coord(size_u, odd_u, r1_u, f1_u, address_mode_u);
      y0 = wrap_coord(size_v, odd_v, r0_v, f0_v, address_mode_v);
      y1 = wrap_coord(size_v, odd_v, r1_v, f1_v, address_mode_v);
      wx = qf_u[15:16-WB];
      wy = qf_v[15:16-WB];
    end else begin
      x0 = wrap_coord(size_u, odd_u, rn_u, fn_u, address_mode_u);
      x1 = x0;
      y0 = wrap_coord(size_v, odd_v, rn_v, fn_v, address_mode_v);
      y1 = y0;
      wx = '0;
      wy = '0;
    end
  end

  function automatic logic [StoreAddrBits-1:0] tex_addr(logic [6:0] x, logic [6:0] y);
    return StoreAddrBits'(32'(y) * MAX_DIM + 32'(x));
  endfunction

  // Stage 3: store port issue, one access per cycle unless a sample waits for queue room.
  logic                     s3_cmd;
  logic                     s3_bil;
  logic [11:0]              s3_waddr;
  logic [31:0]              s3_wdata;
  logic [3:0][StoreAddrBits-1:0] s3_addr;
  logic [WB-1:0]            s3_wx, s3_wy;
  logic [1:0]               s3_phase;
  logic                     s3_fire, s3_last, s3_start;
  logic [FifoCntBits-1:0]   credit;
  logic [FifoCntBits-1:0]   fifo_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (!s3_valid || s3_done) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      s3_cmd   <= s2_cmd;
      s3_bil   <= filter_mode;
      s3_waddr <= s2_waddr;
      s3_wdata <= s2_wdata;
      s3_addr  <= {tex_addr(x1, y1), tex_addr(x0, y1), tex_addr(x1, y0), tex_addr(x0, y0)};
      s3_wx    <= wx;
      s3_wy    <= wy;
    end
  end

  // A sample starts only with room reserved in the result queue.
  assign s3_start = (s3_cmd == CmdWrite) || (s3_phase != 2'd0) ||
                    (credit < FifoCntBits'(FifoDepth));
  assign s3_fire  = s3_valid && s3_start;
  assign s3_last  = (s3_cmd == CmdWrite) || !s3_bil || (s3_phase == 2'd3);
  assign s3_done  = s3_fire && s3_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_phase <= 2'd0;
    end else if (s3_fire) begin
      s3_phase <= s3_last ? 2'd0 : s3_phase + 2'd1;
    end
  end

  // Texel store.
  logic                     mem_we;
  logic [StoreAddrBits-1:0] mem_addr;
  logic [TexelBits-1:0]     mem_rdata;

  assign mem_we   = s3_fire && (s3_cmd == CmdWrite);
  assign mem_addr = (s3_cmd == CmdWrite) ? s3_waddr : s3_addr[s3_phase];

  tsb_ram #(
    .WIDTH (TexelBits),
    .DEPTH (StoreDepth)
  ) u_store (
    .clk   (clk),
    .en    (s3_fire),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (s3_wdata),
    .rdata (mem_rdata)
  );

  // Read return tracking.
  logic          rd_valid, rd_last;
  logic [1:0]    rd_phase;
  logic [WB-1:0] rd_wx, rd_wy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= s3_fire && (s3_cmd == CmdSample);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_fire) begin
      rd_last  <= s3_last;
      rd_phase <= s3_phase;
      rd_wx    <= s3_wx;
      rd_wy    <= s3_wy;
    end
  end

  // Collect the neighbors; the last one is used straight from the store.
  rgba_t              dec;
  rgba_t [3:0]        texel;
  rgba_t [3:0]        tsel;
  logic [WB:0]        ix;
  logic [3:0][BlW-1:0] top_c, bot_c;

  assign dec = decode_texel(mem_rdata, pixel_format);
  assign ix  = WeightOne - (WB + 1)'(rd_wx);

  always_ff @(posedge clk) begin
    if (rst) begin
      texel <= '0;
    end else if (rd_valid && !rd_last) begin
      texel[rd_phase] <= dec;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tsel[k] = (rd_phase == 2'(k)) ? dec : texel[k];
    end
    for (int c = 0; c < 4; c++) begin
      top_c[c] = BlW'(tsel[0][c]) * BlW'(ix) + BlW'(tsel[1][c]) * BlW'(rd_wx);
      bot_c[c] = BlW'(tsel[2][c]) * BlW'(ix) + BlW'(tsel[3][c]) * BlW'(rd_wx);
    end
  end

  // Blend stage 1: horizontal lerps registered.
  logic                b1_valid;
  logic [3:0][BlW-1:0] b1_top, b1_bot;
  logic [WB-1:0]       b1_wy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else begin
      b1_valid <= rd_valid && rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid && rd_last) begin
      b1_top <= top_c;
      b1_bot <= bot_c;
      b1_wy  <= rd_wy;
    end
  end

  // Blend stage 2: vertical lerp, rounding and swizzle.
  logic [WB:0]          iy;
  logic [SumW-1:0]      sum_c;
  rgba_t                blended;
  out_word_t            push_word;

  assign iy = WeightOne - (WB + 1)'(b1_wy);

  always_comb begin
    sum_c   = '0;
    blended = '0;
    for (int c = 0; c < 4; c++) begin
      sum_c      = SumW'(b1_top[c]) * SumW'(iy) + SumW'(b1_bot[c]) * SumW'(b1_wy) + Half;
      blended[c] = sum_c[2*WB+7:2*WB];
    end
    push_word.red   = swizzle_one(blended, channel_swizzle[2:0],  blended[0]);
    push_word.green = swizzle_one(blended, channel_swizzle[5:3],  blended[1]);
    push_word.blue  = swizzle_one(blended, channel_swizzle[8:6],  blended[2]);
    push_word.alpha = swizzle_one(blended, channel_swizzle[11:9], blended[3]);
  end

  // Result queue.
  out_word_t              fifo_mem [FifoDepth];
  logic [FifoPtrBits-1:0] wr_ptr, rd_ptr;
  logic                   pop;

  assign sample_out.valid = (fifo_count != '0);
  assign sample_out.word  = fifo_mem[rd_ptr];
  assign pop              = sample_out.valid && sample_out.ready;

  always_ff @(posedge clk) begin
    if (b1_valid) begin
      fifo_mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
      credit     <= '0;
    end else begin
      if (b1_valid) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fifo_count <= fifo_count + FifoCntBits'(b1_valid) - FifoCntBits'(pop);
      credit     <= credit + FifoCntBits'(s3_fire && (s3_cmd == CmdSample) &&
                                          (s3_phase == 2'd0))
                           - FifoCntBits'(pop);
    end
  end

  // Checks.
  `TSB_ASSERT_ALWAYS(a_credit_bound, credit <= FifoCntBits'(FifoDepth))
  `TSB_ASSERT_ALWAYS(a_queue_within_credit, fifo_count <= credit)
  `TSB_ASSERT_ALWAYS(a_phase_owner, (s3_phase == 2'd0) || (s3_valid && s3_bil && (s3_cmd == CmdSample)))
  `TSB_ASSERT_NEXT(a_last_read_blends, rd_valid && rd_last, b1_valid)

endmodule

// ===== sim/tb_texture_sample_bilinear_top.sv =====
`timescale 1ns / 1ps

module tb_texture_sample_bilinear_top;
  import tsb_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int Dim = 64;
  localparam int WBits = 8;
  localparam int DirRows = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrBits-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tsb_in_if sample_in ();
  tsb_out_if sample_out ();

  texture_sample_bilinear_top uut (
    .clk(clk), .rst(rst), .sample_in(sample_in.sink), .sample_out(sample_out.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Shadow copy of the sampler configuration and of the texel store.
  logic [6:0] cfg_w, cfg_h;
  logic [1:0] cfg_mu, cfg_mv, cfg_fmt;
  logic cfg_filt;
  logic [11:0] cfg_swz;
  logic [31:0] texels [StoreDepth];
  bit written [StoreDepth];

  out_word_t pending_rgba [$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int quiet_cycles = 0;

  // Directed stimulus: writes with typed-in RGBA for samples that are obvious.
  typedef struct {
    in_word_t word;
    bit typed;
    out_word_t rgba;
  } dir_row_t;
  dir_row_t dir_rows [DirRows];

  initial begin
    sample_in.valid = 1'b0;
    sample_in.word = '0;
    sample_out.ready = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("error: %s got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic int floor16(longint p);
    if (p >= 0) return int'(p / 65536);
    return -int'((-p + 65535) / 65536);
  endfunction

  function automatic int wrap_pos(int v, int sz, logic [1:0] mode);
    int r;
    if (sz <= 0) return 0;
    if (mode == ModeRepeat) begin
      r = v % sz;
      return r < 0 ? r + sz : r;
    end
    if (mode == ModeMirror) begin
      r = v % (2 * sz);
      if (r < 0) r += 2 * sz;
      return r < sz ? r : 2 * sz - r - 1;
    end
    if (v < 0) return 0;
    return v > sz - 1 ? sz - 1 : v;
  endfunction

  function automatic rgba_t texel_bytes(int x, int y);
    logic [31:0] w;
    rgba_t t;
    w = texels[(y * Dim + x) & (StoreDepth - 1)];
    t = {8'hFF, 8'h00, 8'h00, 8'h00};
    case (cfg_fmt)
      FmtR8: t[0] = w[7:0];
      FmtRgba: t = {w[31:24], w[23:16], w[15:8], w[7:0]};
      FmtBgra: t = {w[31:24], w[7:0], w[15:8], w[23:16]};
      default: t = {8'hFF, 8'h00, 8'h00, 8'h00};
    endcase
    return t;
  endfunction

  function automatic int eff(logic [6:0] s);
    return s > Dim ? Dim : int'(s);
  endfunction

  // Texel addresses a sample will touch, so random stimulus avoids unwritten words.
  function automatic bit sample_is_safe(logic signed [23:0] u, logic signed [23:0] v);
    longint pu, pv;
    int w, h, x0, y0, ax, ay;
    w = eff(cfg_w);
    h = eff(cfg_h);
    pu = longint'(u) * w;
    pv = longint'(v) * h;
    if (cfg_filt == FilterNearest) begin
      ax = wrap_pos(floor16(pu), w, cfg_mu);
      ay = wrap_pos(floor16(pv), h, cfg_mv);
      return written[(ay * Dim + ax) & (StoreDepth - 1)];
    end
    x0 = floor16(pu - 32768);
    y0 = floor16(pv - 32768);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) begin
        ax = wrap_pos(x0 + i, w, cfg_mu);
        ay = wrap_pos(y0 + j, h, cfg_mv);
        if (!written[(ay * Dim + ax) & (StoreDepth - 1)]) return 0;
      end
    return 1;
  endfunction

  // Predict the RGBA word a sample produces.
  function automatic out_word_t sample_rgba(logic signed [23:0] u, logic signed [23:0] v);
    longint pu, pv, qu, qv;
    int w, h, x0, y0, ax0, ax1, ay0, ay1;
    int unsigned wx, wy, top, bot;
    rgba_t t, a, b, c, d;
    logic [2:0] sel;
    logic [3:0][7:0] o;
    w = eff(cfg_w);
    h = eff(cfg_h);
    pu = longint'(u) * w;
    pv = longint'(v) * h;
    if (cfg_filt == FilterNearest) begin
      t = texel_bytes(wrap_pos(floor16(pu), w, cfg_mu), wrap_pos(floor16(pv), h, cfg_mv));
    end else begin
      qu = pu - 32768;
      qv = pv - 32768;
      x0 = floor16(qu);
      y0 = floor16(qv);
      wx = int'(qu - longint'(x0) * 65536) >> (16 - WBits);
      wy = int'(qv - longint'(y0) * 65536) >> (16 - WBits);
      ax0 = wrap_pos(x0, w, cfg_mu);
      ax1 = wrap_pos(x0 + 1, w, cfg_mu);
      ay0 = wrap_pos(y0, h, cfg_mv);
      ay1 = wrap_pos(y0 + 1, h, cfg_mv);
      a = texel_bytes(ax0, ay0);
      b = texel_bytes(ax1, ay0);
      c = texel_bytes(ax0, ay1);
      d = texel_bytes(ax1, ay1);
      for (int k = 0; k < 4; k++) begin
        top = a[k] * ((1 << WBits) - wx) + b[k] * wx;
        bot = c[k] * ((1 << WBits) - wx) + d[k] * wx;
        t[k] = 8'((top * ((1 << WBits) - wy) + bot * wy + (1 << (2 * WBits - 1)))
                  >> (2 * WBits));
      end
    end
    for (int k = 0; k < 4; k++) begin
      sel = cfg_swz[3 * k +: 3];
      case (sel)
        SwzZero: o[k] = 8'h00;
        SwzOne: o[k] = 8'hFF;
        SwzR: o[k] = t[0];
        SwzG: o[k] = t[1];
        SwzB: o[k] = t[2];
        SwzA: o[k] = t[3];
        default: o[k] = t[k];
      endcase
    end
    return '{red: o[0], green: o[1], blue: o[2], alpha: o[3]};
  endfunction

  // Shadow store updates happen in the driver, so predictions follow program order.
  // Valid stays high after an accepted word; the next word, an idle cycle or the
  // settle task decides what it does next.
  task automatic send_word(input in_word_t wd);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      sample_in.valid <= 1'b0;
      @(posedge clk);
    end
    sample_in.valid <= 1'b1;
    sample_in.word <= wd;
    @(posedge clk);
    while (!sample_in.ready) @(posedge clk);
  endtask

  task automatic issue(input in_word_t wd, input bit typed, input out_word_t want);
    out_word_t p;
    if (wd.command == CmdWrite) begin
      texels[wd.texel_address] = wd.texel_data;
      written[wd.texel_address] = 1'b1;
    end else begin
      p = sample_rgba(wd.coord_u, wd.coord_v);
      if (typed && p != want) begin
        $display("error: directed row expectation %h differs from prediction %h", want, p);
        errors++;
      end
      pending_rgba.push_back(typed ? want : p);
    end
    send_word(wd);
  endtask

  // One APB write; the caller drops psel once its last write is done.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CfgAddrBits'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      RegTexWidth: cfg_w = val[6:0];
      RegTexHeight: cfg_h = val[6:0];
      RegModeU: cfg_mu = val[1:0];
      RegModeV: cfg_mv = val[1:0];
      RegFilter: cfg_filt = val[0];
      RegFormat: cfg_fmt = val[1:0];
      default: cfg_swz = val[11:0];
    endcase
  endtask

  // Drain outstanding results, then give the bilinear pipe time to settle.
  task automatic settle;
    sample_in.valid <= 1'b0;
    while (pending_rgba.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic configure(input logic [6:0] w, input logic [6:0] h, input logic [1:0] mu,
                           input logic [1:0] mv, input logic f, input logic [1:0] fmt,
                           input logic [11:0] swz);
    settle();
    write_reg(RegTexWidth, 32'(w));
    write_reg(RegTexHeight, 32'(h));
    write_reg(RegModeU, 32'(mu));
    write_reg(RegModeV, 32'(mv));
    write_reg(RegFilter, 32'(f));
    write_reg(RegFormat, 32'(fmt));
    write_reg(RegSwizzle, 32'(swz));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic in_word_t wr_word(int addr, logic [31:0] d);
    in_word_t x;
    x = '0;
    x.command = CmdWrite;
    x.texel_address = 12'(addr);
    x.texel_data = d;
    x.coord_u = 24'($urandom);
    x.coord_v = 24'($urandom);
    return x;
  endfunction

  function automatic in_word_t smp_word(logic signed [23:0] u, logic signed [23:0] v);
    in_word_t x;
    x.command = CmdSample;
    x.texel_address = 12'($urandom);
    x.texel_data = $urandom;
    x.coord_u = u;
    x.coord_v = v;
    return x;
  endfunction

  // Fill the whole texture area of the current size with random texels.
  task automatic fill_texture(input int w, input int h);
    for (int y = 0; y < (h == 0 ? 1 : h); y++)
      for (int x = 0; x < (w == 0 ? 1 : w); x++)
        issue(wr_word(y * Dim + x, $urandom), 0, '0);
  endtask

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'sd65536 * $signed(24'($urandom_range(6))) - 24'sd196608
                + 24'($urandom_range(65535));
      2: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      default: return 24'($urandom_range(65536));
    endcase
  endfunction

  task automatic random_phase(input int samples, input int w, input int h);
    logic signed [23:0] u, v;
    for (int n = 0; n < samples; n++) begin
      if ($urandom_range(9) == 0) begin
        // Rewrite a texel inside the active area with new content.
        issue(wr_word($urandom_range(h == 0 ? 0 : h - 1) * Dim
                      + $urandom_range(w == 0 ? 0 : w - 1), $urandom), 0, '0);
      end else begin
        u = rand_coord();
        v = rand_coord();
        if (sample_is_safe(u, v)) issue(smp_word(u, v), 0, '0);
      end
    end
  endtask

  // Receiver: random stalls, result check against the oldest prediction.
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      sample_out.ready <= 1'b0;
    end else begin
      sample_out.ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
      if (sample_out.valid && sample_out.ready) begin
        if (pending_rgba.size() == 0) begin
          $display("error: result with no sample outstanding");
          errors++;
        end else begin
          want = pending_rgba.pop_front();
          if (sample_out.word.red !== want.red)
            report_mismatch("red", sample_out.word.red, want.red);
          if (sample_out.word.green !== want.green)
            report_mismatch("green", sample_out.word.green, want.green);
          if (sample_out.word.blue !== want.blue)
            report_mismatch("blue", sample_out.word.blue, want.blue);
          if (sample_out.word.alpha !== want.alpha)
            report_mismatch("alpha", sample_out.word.alpha, want.alpha);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((sample_in.valid && sample_in.ready) || (sample_out.valid && sample_out.ready)
        || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (!rst) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("texture_sample_bilinear_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int sw, sh;
    cfg_w = 7'd1;
    cfg_h = 7'd1;
    cfg_mu = ModeRepeat;
    cfg_mv = ModeRepeat;
    cfg_filt = FilterNearest;
    cfg_fmt = FmtRgba;
    cfg_swz = '0;
    foreach (written[i]) written[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table under reset settings: 1x1 texture, nearest, RGBA.
    dir_rows[0] = '{wr_word(0, 32'h4433_2211), 0, '0};
    dir_rows[1] = '{smp_word(24'sh000000, 24'sh000000), 1,
                    '{red: 8'h11, green: 8'h22, blue: 8'h33, alpha: 8'h44}};
    dir_rows[2] = '{smp_word(24'sh7FFFFF, 24'sh800000), 1,
                    '{red: 8'h11, green: 8'h22, blue: 8'h33, alpha: 8'h44}};
    dir_rows[3] = '{smp_word(24'sh800000, 24'sh7FFFFF), 1,
                    '{red: 8'h11, green: 8'h22, blue: 8'h33, alpha: 8'h44}};
    dir_rows[4] = '{wr_word(0, 32'hFFFF_FFFF), 0, '0};
    dir_rows[5] = '{smp_word(24'sh123456, 24'shFEDCBA), 1,
                    '{red: 8'hFF, green: 8'hFF, blue: 8'hFF, alpha: 8'hFF}};
    dir_rows[6] = '{wr_word(0, 32'h0000_0000), 0, '0};
    dir_rows[7] = '{smp_word(24'sh010000, 24'sh010000), 1,
                    '{red: 8'h00, green: 8'h00, blue: 8'h00, alpha: 8'h00}};
    dir_rows[8] = '{wr_word(12'hFFF, 32'hA5A5_5A5A), 0, '0};
    dir_rows[9] = '{wr_word(0, 32'h8040_2010), 0, '0};
    for (int i = 10; i < DirRows; i++)
      dir_rows[i] = '{smp_word(24'(i * 40000 - 300000), 24'(-i * 30000)), 0, '0};
    foreach (dir_rows[i]) issue(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].rgba);

    // Formats, swizzles and a zero dimension, with bilinear on a 0x0 map.
    configure(7'd0, 7'd0, ModeMirror, ModeClamp, FilterBilinear, FmtUndef, 12'o1234);
    issue(smp_word(24'sh400000, 24'shC00000), 1,
          '{red: 8'h00, green: 8'h00, blue: 8'hFF, alpha: 8'h00});
    configure(7'd1, 7'd1, ModeBorder, ModeBorder, FilterNearest, FmtR8, 12'o7654);
    issue(smp_word(24'sh000000, 24'sh000000), 0, '0);
    configure(7'd1, 7'd1, ModeRepeat, ModeMirror, FilterNearest, FmtBgra, 12'o3333);
    issue(smp_word(24'sh008000, 24'sh008000), 0, '0);

    // Random phases over a spread of sizes, modes and idling patterns.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin sw = 2; sh = 64; end
        1: begin sw = 1; sh = 1; end
        2: begin sw = 127; sh = 2; end
        default: begin sw = $urandom_range(1, 12); sh = $urandom_range(1, 12); end
      endcase
      if (ph < 4) begin send_idle = 14; recv_idle = 72; end
      else if (ph < 8) begin send_idle = 72; recv_idle = 14; end
      else begin send_idle = 0; recv_idle = 0; end
      configure(7'(sw), 7'(sh), 2'($urandom), 2'($urandom), ph[0],
                ph == 2 ? FmtBgra : 2'($urandom), ph == 3 ? 12'hFFF : 12'($urandom));
      if (ph < 3 || ph > 3) fill_texture(eff(7'(sw)), eff(7'(sh)));
      random_phase(ph == 0 ? 80 : 60, eff(7'(sw)), eff(7'(sh)));
    end

    settle();
    if (errors == 0) begin
      $display("texture_sample_bilinear_top: match");
    end else begin
      $display("texture_sample_bilinear_top: mismatch");
    end
    $finish;
  end

endmodule
